### rtl/pclq_pkg.sv
// pclq_pkg: field widths, operation and status codes, parameter defaults
// for the per-client line queue block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pclq_pkg;

  // fixed field widths
  localparam int OP_BITS     = 3;
  localparam int KEY_BITS    = 16;
  localparam int WORD_BITS   = 32;
  localparam int STATUS_BITS = 3;
  localparam int FILL_BITS   = 4;

  // parameter defaults
  localparam int DEF_CLIENT_SLOTS = 16;
  localparam int DEF_QUEUE_DEPTH  = 8;
  localparam int DEF_HANDLE_BITS  = 32;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_OPEN   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_CLOSE  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_BITS-1:0] OP_POP    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_ALREADY    = 3'd5;

endpackage

`default_nettype wire

### rtl/per_client_line_queues.sv
// per_client_line_queues: client slot table in flip-flops plus one shared
// line store memory holding every client's ring queue. Uses pclq_pkg.
//
// Each request returns exactly one result. A request passes through S_LOOKUP,
// which looks the key up in the slot table, updates the slot and issues the
// line store access, and then S_FINISH, which takes the registered read data
// of the line store into the output register. With the output taken at once,
// a new request is accepted in S_FINISH as the last result is registered;
// a stalled output holds the block in S_FINISH and keeps in_ready low.
// The line store needs no clearing pass after reset, since a pop only reads
// entries an earlier append has written; the block is ready right out of
// reset. Handles are stored at HANDLE_BITS bits and returned on the low 32.
`timescale 1ns / 1ps
`default_nettype none

module per_client_line_queues
  import pclq_pkg::*;
#(
  parameter int CLIENT_SLOTS = DEF_CLIENT_SLOTS,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS  = DEF_HANDLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [OP_BITS-1:0]     op,
  input  wire logic [KEY_BITS-1:0]    client_key,
  input  wire logic [WORD_BITS-1:0]   message_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [STATUS_BITS-1:0]      status_code,
  output logic [WORD_BITS-1:0]        message_out,
  output logic                        message_valid,
  output logic [FILL_BITS-1:0]        fill_after
);

  localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = SW + PW;
  localparam int MEM_DEPTH = 1 << AW;

  localparam logic [FW-1:0] DEPTH_F  = FW'(QUEUE_DEPTH);
  localparam logic [PW:0]   DEPTH_P  = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  // slot table
  logic [CLIENT_SLOTS-1:0] slot_used;
  logic [KEY_BITS-1:0]     slot_key  [CLIENT_SLOTS];
  logic [PW-1:0]           read_pointer [CLIENT_SLOTS];
  logic [FW-1:0]           fill_count   [CLIENT_SLOTS];

  // line store
  logic [HANDLE_BITS-1:0] line_store [MEM_DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;

  // captured request
  logic [OP_BITS-1:0]   req_op;
  logic [KEY_BITS-1:0]  req_key;
  logic [WORD_BITS-1:0] req_word;

  // results held between lookup and output
  logic [STATUS_BITS-1:0] pend_status;
  logic [FW-1:0]          pend_fill;
  logic                   pend_pop;

  // lookup results
  logic                   found;
  logic [SW-1:0]          match_idx;
  logic                   has_free;
  logic [SW-1:0]          free_idx;
  logic [PW-1:0]          cur_rp;
  logic [FW-1:0]          cur_fill;
  logic [PW:0]            pos_sum;
  logic [PW-1:0]          wr_pos;
  logic [STATUS_BITS-1:0] lk_status;
  logic [FW-1:0]          lk_fill;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_addr;
  logic [HANDLE_BITS-1:0] wr_data;
  logic [HANDLE_BITS+WORD_BITS-1:0] wr_ext;
  logic [HANDLE_BITS+WORD_BITS-1:0] rd_ext;
  logic [FW+FILL_BITS-1:0]          fill_ext;

  logic out_free;
  logic in_acc;
  logic in_lookup;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !rst && ((state == S_IDLE) || ((state == S_FINISH) && out_free));
  assign in_acc    = in_valid && in_ready;
  assign in_lookup = (state == S_LOOKUP);

  // key match and free slot search, lowest index wins
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    has_free  = 1'b0;
    free_idx  = '0;
    for (int i = 0; i < CLIENT_SLOTS; i++) begin
      if (!found && slot_used[i] && (slot_key[i] == req_key)) begin
        found     = 1'b1;
        match_idx = SW'(i);
      end
      if (!has_free && !slot_used[i]) begin
        has_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign cur_rp   = read_pointer[match_idx];
  assign cur_fill = fill_count[match_idx];
  // write position wraps once at most since both terms stay below the depth
  assign pos_sum  = {1'b0, cur_rp} + {1'b0, cur_fill[PW-1:0]};
  assign wr_pos   = (pos_sum >= DEPTH_P) ? PW'(pos_sum - DEPTH_P) : pos_sum[PW-1:0];
  assign wr_ext   = {{HANDLE_BITS{1'b0}}, req_word};
  assign wr_data  = wr_ext[HANDLE_BITS-1:0];

  always_comb begin
    lk_status = ST_OK;
    lk_fill   = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {match_idx, cur_rp};
    case (req_op)
      OP_OPEN: begin
        if (found) begin
          lk_status = ST_ALREADY;
        end else if (!has_free) begin
          lk_status = ST_TABLE_FULL;
        end
      end
      OP_CLOSE: begin
        if (!found) begin
          lk_status = ST_UNKNOWN;
        end
      end
      OP_APPEND: begin
        if (!found) begin
          lk_status = ST_UNKNOWN;
        end else if (cur_fill >= DEPTH_F) begin
          lk_status = ST_FULL;
          lk_fill   = cur_fill;
        end else begin
          lk_fill  = cur_fill + FW'(1);
          mem_we   = in_lookup;
          mem_addr = {match_idx, wr_pos};
        end
      end
      OP_POP: begin
        if (!found) begin
          lk_status = ST_UNKNOWN;
        end else if (cur_fill == '0) begin
          lk_status = ST_EMPTY;
        end else begin
          lk_fill = cur_fill - FW'(1);
          mem_re  = in_lookup;
        end
      end
      default: begin
      end
    endcase
  end

  // line store, at most one access per request
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= line_store[mem_addr];
    end
  end

  // slot table update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        read_pointer[i] <= '0;
        fill_count[i]   <= '0;
      end
    end else if (in_lookup) begin
      case (req_op)
        OP_OPEN: begin
          if (!found && has_free) begin
            slot_used[free_idx]    <= 1'b1;
            slot_key[free_idx]     <= req_key;
            read_pointer[free_idx] <= '0;
            fill_count[free_idx]   <= '0;
          end
        end
        OP_CLOSE: begin
          if (found) begin
            slot_used[match_idx]    <= 1'b0;
            read_pointer[match_idx] <= '0;
            fill_count[match_idx]   <= '0;
          end
        end
        OP_APPEND: begin
          if (mem_we) begin
            fill_count[match_idx] <= lk_fill;
          end
        end
        OP_POP: begin
          if (mem_re) begin
            fill_count[match_idx]   <= lk_fill;
            read_pointer[match_idx] <= (cur_rp == LAST_POS) ? '0 : cur_rp + PW'(1);
          end
        end
        OP_CLEAR: begin
          slot_used <= '0;
          for (int i = 0; i < CLIENT_SLOTS; i++) begin
            read_pointer[i] <= '0;
            fill_count[i]   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request capture and lookup results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op   <= op;
      req_key  <= client_key;
      req_word <= message_word;
    end
    if (in_lookup) begin
      pend_status <= lk_status;
      pend_fill   <= lk_fill;
      pend_pop    <= mem_re;
    end
  end

  assign rd_ext   = {{WORD_BITS{1'b0}}, rd_data};
  assign fill_ext = {{FILL_BITS{1'b0}}, pend_fill};

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status_code   <= pend_status;
            message_valid <= pend_pop;
            message_out   <= pend_pop ? rd_ext[WORD_BITS-1:0] : '0;
            fill_after    <= fill_ext[FILL_BITS-1:0];
            state         <= in_acc ? S_LOOKUP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the line store is never written and read in the same cycle
  a_mem_one_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("line store written and read in one cycle");

  // an addressed open queue never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (in_lookup && found) |-> (cur_fill <= DEPTH_F))
    else $error("queue fill above depth");

  // a popped handle is only reported with ok status
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_valid) |-> (status_code == ST_OK))
    else $error("popped handle with error status");

  // a pending pop result follows a lookup that issued the read
  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    (in_lookup && mem_re) |=> (state == S_FINISH) && pend_pop)
    else $error("pop read not carried to finish");

endmodule

`default_nettype wire

### sim/tb_per_client_line_queues.sv
// tb_per_client_line_queues: self-checking testbench for per_client_line_queues.
// Drives requests through valid/ready, predicts each result from its own slot
// table model and checks every result field. Depends on rtl/pclq_pkg.sv and the DUT.
`timescale 1ns / 1ps

module tb_per_client_line_queues;
  import pclq_pkg::*;

  localparam int SLOTS = DEF_CLIENT_SLOTS;
  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int POOL_KEYS = 32;
  localparam int MAX_PRINTS = 40;

  // op codes the block treats as no operation
  localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [WORD_BITS-1:0]   word;
    logic                   word_valid;
    logic [FILL_BITS-1:0]   fill;
  } line_result_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_LONG} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_BITS-1:0]     op;
  logic [KEY_BITS-1:0]    client_key;
  logic [WORD_BITS-1:0]   message_word;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_BITS-1:0] status_code;
  logic [WORD_BITS-1:0]   message_out;
  logic                   message_valid;
  logic [FILL_BITS-1:0]   fill_after;

  // model of the slot table and line store
  logic                 slot_open[SLOTS];
  logic [KEY_BITS-1:0]  slot_owner[SLOTS];
  int                   slot_head[SLOTS];
  int                   slot_lines[SLOTS];
  logic [WORD_BITS-1:0] line_mem[SLOTS][DEPTH];

  line_result_t        expected_lines[$];
  logic [KEY_BITS-1:0] key_pool[POOL_KEYS];
  int                  mismatches = 0;
  int                  gap_max = 0;
  int                  burst_left = 0;
  stall_mode_t         stall_mode = STALL_NONE;
  int                  stall_phase = 0;
  int                  stall_left = 0;

  per_client_line_queues u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .client_key   (client_key),
    .message_word (message_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status_code  (status_code),
    .message_out  (message_out),
    .message_valid(message_valid),
    .fill_after   (fill_after)
  );

  always #6 clk = ~clk;

  function automatic void clear_slot_table();
    for (int s = 0; s < SLOTS; s++) begin
      slot_open[s]  = 1'b0;
      slot_owner[s] = '0;
      slot_head[s]  = 0;
      slot_lines[s] = 0;
    end
  endfunction

  // applies one request to the model and returns the result it must produce
  function automatic line_result_t predict_line_op(input logic [OP_BITS-1:0] opc,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [WORD_BITS-1:0] word);
    line_result_t r;
    int hit;
    int free_slot;
    int pos;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (hit < 0 && slot_open[s] && slot_owner[s] == key) hit = s;
      if (free_slot < 0 && !slot_open[s]) free_slot = s;
    end
    case (opc)
      OP_OPEN: begin
        if (hit >= 0) begin
          r.status = ST_ALREADY;
        end else if (free_slot < 0) begin
          r.status = ST_TABLE_FULL;
        end else begin
          slot_open[free_slot]  = 1'b1;
          slot_owner[free_slot] = key;
          slot_head[free_slot]  = 0;
          slot_lines[free_slot] = 0;
        end
      end
      OP_CLOSE: begin
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          slot_open[hit]  = 1'b0;
          slot_head[hit]  = 0;
          slot_lines[hit] = 0;
        end
      end
      OP_APPEND: begin
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else if (slot_lines[hit] >= DEPTH) begin
          r.status = ST_FULL;
          r.fill = FILL_BITS'(slot_lines[hit]);
        end else begin
          pos = (slot_head[hit] + slot_lines[hit]) % DEPTH;
          line_mem[hit][pos] = word;
          slot_lines[hit]++;
          r.fill = FILL_BITS'(slot_lines[hit]);
        end
      end
      OP_POP: begin
        if (hit < 0) begin
          r.status = ST_UNKNOWN;
        end else if (slot_lines[hit] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = line_mem[hit][slot_head[hit]];
          r.word_valid = 1'b1;
          slot_head[hit] = (slot_head[hit] + 1) % DEPTH;
          slot_lines[hit]--;
          r.fill = FILL_BITS'(slot_lines[hit]);
        end
      end
      OP_CLEAR: clear_slot_table();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // one request: held until accepted, then bursts end in a random gap
  task automatic send_request(input logic [OP_BITS-1:0] opc,
                              input logic [KEY_BITS-1:0] key,
                              input logic [WORD_BITS-1:0] word);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= opc;
    client_key   <= key;
    message_word <= word;
    do @(posedge clk); while (!in_ready);
    expected_lines.push_back(predict_line_op(opc, key, word));
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(gap_max, 1);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(12, 1);
      end
    end
  endtask

  // holds the sender off until every outstanding result is back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_traffic(input int count, input int w_open, input int w_close,
                                input int w_append, input int w_pop);
    int pick;
    logic [OP_BITS-1:0] opc;
    logic [KEY_BITS-1:0] key;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < w_open) opc = OP_OPEN;
      else if (pick < w_open + w_close) opc = OP_CLOSE;
      else if (pick < w_open + w_close + w_append) opc = OP_APPEND;
      else if (pick < w_open + w_close + w_append + w_pop) opc = OP_POP;
      else if (pick == 99) opc = OP_CLEAR;
      else opc = OP_BITS'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      if ($urandom_range(19) == 0) key = KEY_BITS'($urandom());
      else key = key_pool[$urandom_range(POOL_KEYS - 1)];
      send_request(opc, key, $urandom());
    end
  endtask

  task automatic test_basic_ops();
    send_request(OP_OPEN, 16'h0000, 32'h0);
    send_request(OP_OPEN, 16'h0000, 32'h0);
    send_request(OP_APPEND, 16'h0000, 32'h0000_0000);
    send_request(OP_APPEND, 16'h0000, 32'hFFFF_FFFF);
    send_request(OP_POP, 16'h0000, 32'h0);
    send_request(OP_APPEND, 16'hFFFF, 32'hA5A5_5A5A);
    send_request(OP_POP, 16'hFFFF, 32'h0);
    send_request(OP_CLOSE, 16'hFFFF, 32'h0);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
      send_request(OP_CLOSE - OP_CLOSE + c[OP_BITS-1:0], 16'h0000, 32'hFFFF_FFFF);
    // first slot closed with a line still pending
    send_request(OP_CLOSE, 16'h0000, 32'h0);
    send_request(OP_OPEN, 16'h0000, 32'h0);
    send_request(OP_POP, 16'h0000, 32'h0);
    send_request(OP_CLEAR, 16'h0000, 32'h0);
    send_request(OP_APPEND, 16'h0000, 32'h1234_5678);
  endtask

  task automatic test_queue_wrap();
    send_request(OP_OPEN, 16'hFFFF, 32'h0);
    for (int i = 0; i < DEPTH + 1; i++) send_request(OP_APPEND, 16'hFFFF, $urandom());
    repeat (2) send_request(OP_POP, 16'hFFFF, 32'h0);
    repeat (2) send_request(OP_APPEND, 16'hFFFF, $urandom());
    send_request(OP_CLOSE, 16'hFFFF, 32'h0);
  endtask

  task automatic test_table_full();
    send_request(OP_CLEAR, 16'h0000, 32'h0);
    for (int i = 0; i <= SLOTS; i++) send_request(OP_OPEN, key_pool[i], 32'h0);
    send_request(OP_OPEN, key_pool[3], 32'h0);
    send_request(OP_CLOSE, key_pool[0], 32'h0);
    // freed first slot is reused by the next open
    send_request(OP_OPEN, key_pool[20], 32'h0);
    send_request(OP_APPEND, key_pool[20], $urandom());
    send_request(OP_POP, key_pool[20], 32'h0);
  endtask

  task automatic test_streaming();
    gap_max = 0;
    stall_mode = STALL_NONE;
    random_traffic(350, 12, 5, 42, 38);
  endtask

  task automatic test_bursty_sender();
    gap_max = 6;
    burst_left = 3;
    stall_mode = STALL_RANDOM;
    random_traffic(350, 10, 3, 55, 29);
  endtask

  task automatic test_stalled_receiver();
    gap_max = 0;
    stall_mode = STALL_PATTERN;
    random_traffic(350, 10, 4, 35, 48);
  endtask

  task automatic test_mixed_idling();
    gap_max = 10;
    burst_left = 1;
    stall_mode = STALL_LONG;
    random_traffic(350, 25, 18, 30, 24);
  endtask

  // receiver stall patterns
  always @(negedge clk) begin
    case (stall_mode)
      STALL_NONE: out_ready <= 1'b1;
      STALL_RANDOM: out_ready <= ($urandom_range(3) != 0);
      STALL_PATTERN: begin
        out_ready   <= (stall_phase % 7) >= 3;
        stall_phase <= stall_phase + 1;
      end
      default: begin
        if (stall_left > 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(9) == 0) stall_left <= $urandom_range(16, 1);
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_result
    line_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_lines.pop_front();
        if (status_code !== want.status)
          report_mismatch($sformatf("status_code got %0d want %0d", status_code, want.status));
        if (message_out !== want.word)
          report_mismatch($sformatf("message_out got %h want %h", message_out, want.word));
        if (message_valid !== want.word_valid)
          report_mismatch($sformatf("message_valid got %b want %b",
                                    message_valid, want.word_valid));
        if (fill_after !== want.fill)
          report_mismatch($sformatf("fill_after got %0d want %0d", fill_after, want.fill));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_OPEN;
    client_key   = '0;
    message_word = '0;
    clear_slot_table();
    // distinct keys: index in the top bits, random low bits
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {i[4:0], 11'($urandom())};
    key_pool[0] = 16'h0000;
    key_pool[POOL_KEYS - 1] = 16'hFFFF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_queue_wrap();
    wait_for_drain();
    test_table_full();
    wait_for_drain();
    test_streaming();
    wait_for_drain();
    test_bursty_sender();
    wait_for_drain();
    test_stalled_receiver();
    wait_for_drain();
    test_mixed_idling();
    wait_for_drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
